FILE: src/pfi_pkg.sv
`default_nettype none

package pfi_pkg;

    // defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths on the ports
    localparam int IN_FIELD_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int SIZE_W      = 7;
    localparam int SUM_W       = 32;
    localparam int OUT_TDATA_W = 48;

    // operation a cell performs in the current cycle
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_SHIFT = 2'd2
    } t_cell_op;

    // frontier-wide decision, broadcast to every cell during evaluation
    typedef struct packed {
        logic dom;   // some stored point dominates the new one
        logic same;  // some stored point has the same x
        logic rem;   // some stored point is dominated by the new one
        logic full;  // store holds CAPACITY points
    } t_eval_ctl;

    // per-cell status seen by the top level and the neighbors
    typedef struct packed {
        logic lt;     // live and x below the new x
        logic rem;    // live, x below and y not above the new point
        logic dom;    // live, x not below and y above the new point
        logic same;   // live and x equal to the new x
        logic dead;   // marked for removal by the compaction
        logic above;  // sits above the removed run, moves down with it
    } t_cell_flags;

endpackage

`default_nettype wire

FILE: src/pfi_cell.sv
`default_nettype none

module pfi_cell
    import pfi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_op              i_op,
    input  wire t_eval_ctl             i_ctl,
    input  wire logic                  i_live,
    input  wire logic [COORD_BITS-1:0] i_px,
    input  wire logic [COORD_BITS-1:0] i_py,
    input  wire logic [COORD_BITS-1:0] i_prev_x,
    input  wire logic [COORD_BITS-1:0] i_prev_y,
    input  wire logic                  i_prev_lt,
    input  wire logic [COORD_BITS-1:0] i_next_x,
    input  wire logic [COORD_BITS-1:0] i_next_y,
    input  wire t_cell_flags           i_next_flags,
    output logic [COORD_BITS-1:0]      o_x,
    output logic [COORD_BITS-1:0]      o_y,
    output t_cell_flags                o_flags
);

    logic [COORD_BITS-1:0] r_x, r_y, n_x, n_y;
    logic                  r_dead, r_above, n_dead, n_above;
    logic                  w_lt, w_ge, w_rem, w_dom, w_same;

    always_comb begin
        w_lt   = i_live && (r_x < i_px);
        w_ge   = i_live && !w_lt;
        w_rem  = w_lt && (r_y <= i_py);
        w_dom  = w_ge && (r_y > i_py);
        w_same = i_live && (r_x == i_px);
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_dead  = r_dead;
        n_above = r_above;
        case (i_op)
            OP_EVAL: begin
                n_dead  = 1'b0;
                n_above = 1'b0;
                if (i_ctl.dom) begin
                    // store unchanged
                end else if (i_ctl.same) begin
                    if (w_same) begin
                        n_y = i_py;
                    end
                    n_dead  = w_rem;
                    n_above = !w_lt;
                end else if (i_ctl.rem) begin
                    // topmost removed point makes room for the new one
                    if (w_rem && !i_next_flags.rem) begin
                        n_x     = i_px;
                        n_y     = i_py;
                        n_above = 1'b1;
                    end else begin
                        n_dead  = w_rem;
                        n_above = !w_lt;
                    end
                end else if (!i_ctl.full && !w_lt) begin
                    // open a slot: everything from the insert point moves up
                    if (i_prev_lt) begin
                        n_x = i_px;
                        n_y = i_py;
                    end else begin
                        n_x = i_prev_x;
                        n_y = i_prev_y;
                    end
                end
            end
            OP_SHIFT: begin
                if ((r_dead && !i_next_flags.dead) || (r_above && !r_dead)) begin
                    n_x     = i_next_x;
                    n_y     = i_next_y;
                    n_dead  = i_next_flags.dead;
                    n_above = i_next_flags.above;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead  <= 1'b0;
            r_above <= 1'b0;
        end else begin
            r_dead  <= n_dead;
            r_above <= n_above;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_x = r_x;
    assign o_y = r_y;

    always_comb begin
        o_flags       = '0;
        o_flags.lt    = w_lt;
        o_flags.rem   = w_rem;
        o_flags.dom   = w_dom;
        o_flags.same  = w_same;
        o_flags.dead  = r_dead;
        o_flags.above = r_above;
    end

endmodule

`default_nettype wire

FILE: src/pareto_frontier_insert.sv
// Two-dimensional Pareto frontier kept in a row of CAPACITY cells, sorted by
// rising x with strictly falling y. Each input transfer carries one point;
// each point gives exactly one output transfer with the dominated flag, the
// frontier size after the point, the saturating running sum of sizes since
// the last start of a set, and an overflow flag for a point lost to a full
// store. Setting start_new_set empties the frontier and the sum before the
// point is handled. Timing: a point is compared against all cells in
// parallel in the cycle it is transferred; S_WORK then squeezes out of the
// row each stored point that has to go and loads the result into the output
// register once the row is compact and the register is free. Removal shifts
// the upper part of the row down one cell per cycle; every removed point is
// squeezed out when the point replaces an equal x, and all but the topmost
// one, whose slot the new point takes, when it takes the slot of a removed
// point. A stored point is removed at most once. The next point is taken
// while an earlier result still waits in the output register; a result that
// cannot leave holds the block until the output transfer completes.

`default_nettype none

module pareto_frontier_insert
    import pfi_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input points
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // px[15:0], py[31:16]
    input  wire logic                   i_s_tuser,   // start_new_set
    // results
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata    // was_dominated[0], frontier_size[7:1],
                                                     // running_total[39:8], overflow[40],
                                                     // zero[47:41]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = COORD_BITS + IN_FIELD_W;
    localparam int SZX_W = CNT_W + SIZE_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,   // waiting for a point
        S_WORK = 2'b10    // compacting, then handing the result out
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count, n_count, w_eff_count;
    logic [SUM_W-1:0] r_sum, n_sum, w_sum_sat;
    logic [SUM_W:0]   w_sum_wide;
    logic             r_dom, n_dom, r_ovf, n_ovf;

    // output register
    logic                   r_m_tvalid, n_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    logic w_in_xfer, w_out_free;

    // incoming coordinates, cut or widened to the stored width
    logic [EXT_W-1:0]      w_px_ext, w_py_ext;
    logic [COORD_BITS-1:0] w_px, w_py;

    logic [SZX_W-1:0]  w_size_ext;

    // cell row
    t_cell_op              w_op;
    t_eval_ctl             w_ctl;
    logic [CAPACITY-1:0]   w_live, w_rem, w_dom, w_same, w_dead;
    logic [COORD_BITS-1:0] w_cx [CAPACITY];
    logic [COORD_BITS-1:0] w_cy [CAPACITY];
    t_cell_flags           w_cf [CAPACITY];
    t_cell_flags           w_top_flags;

    assign w_px_ext = EXT_W'(i_s_tdata[IN_FIELD_W-1:0]);
    assign w_py_ext = EXT_W'(i_s_tdata[IN_TDATA_W-1:IN_FIELD_W]);
    assign w_px     = w_px_ext[COORD_BITS-1:0];
    assign w_py     = w_py_ext[COORD_BITS-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    // a new set starts from an empty row
    assign w_eff_count = i_s_tuser ? '0 : r_count;

    // neighbor beyond the last cell: nothing to remove, always above
    always_comb begin
        w_top_flags       = '0;
        w_top_flags.above = 1'b1;
    end

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic [COORD_BITS-1:0] w_prev_x, w_prev_y, w_next_x, w_next_y;
            logic                  w_prev_lt;
            t_cell_flags           w_next_flags;

            assign w_live[k] = (CNT_W'(k) < w_eff_count);

            if (k == 0) begin : g_first
                assign w_prev_x  = w_cx[k];
                assign w_prev_y  = w_cy[k];
                assign w_prev_lt = 1'b1;
            end else begin : g_inner_prev
                assign w_prev_x  = w_cx[k-1];
                assign w_prev_y  = w_cy[k-1];
                assign w_prev_lt = w_cf[k-1].lt;
            end

            if (k == CAPACITY - 1) begin : g_last
                assign w_next_x     = w_cx[k];
                assign w_next_y     = w_cy[k];
                assign w_next_flags = w_top_flags;
            end else begin : g_inner_next
                assign w_next_x     = w_cx[k+1];
                assign w_next_y     = w_cy[k+1];
                assign w_next_flags = w_cf[k+1];
            end

            pfi_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_op         (w_op),
                .i_ctl        (w_ctl),
                .i_live       (w_live[k]),
                .i_px         (w_px),
                .i_py         (w_py),
                .i_prev_x     (w_prev_x),
                .i_prev_y     (w_prev_y),
                .i_prev_lt    (w_prev_lt),
                .i_next_x     (w_next_x),
                .i_next_y     (w_next_y),
                .i_next_flags (w_next_flags),
                .o_x          (w_cx[k]),
                .o_y          (w_cy[k]),
                .o_flags      (w_cf[k])
            );

            assign w_rem[k]  = w_cf[k].rem;
            assign w_dom[k]  = w_cf[k].dom;
            assign w_same[k] = w_cf[k].same;
            assign w_dead[k] = w_cf[k].dead;
        end
    endgenerate

    // frontier-wide decision from the parallel compares
    always_comb begin
        w_ctl      = '0;
        w_ctl.dom  = |w_dom;
        w_ctl.same = |w_same;
        w_ctl.rem  = |w_rem;
        w_ctl.full = (w_eff_count == CNT_W'(CAPACITY));
    end

    // saturating running sum over the final size of this point
    assign w_sum_wide = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_count);
    assign w_sum_sat  = w_sum_wide[SUM_W] ? '1 : w_sum_wide[SUM_W-1:0];
    assign w_size_ext = SZX_W'(r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sum      = r_sum;
        n_dom      = r_dom;
        n_ovf      = r_ovf;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        w_op       = OP_HOLD;

        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_op    = OP_EVAL;
                    n_dom   = w_ctl.dom;
                    n_ovf   = 1'b0;
                    n_count = w_eff_count;
                    if (i_s_tuser) begin
                        n_sum = '0;
                    end
                    if (!w_ctl.dom && !w_ctl.same && !w_ctl.rem) begin
                        if (w_ctl.full) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_count = w_eff_count + CNT_W'(1);
                        end
                    end
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (|w_dead) begin
                    // squeeze one removed point out per cycle
                    w_op    = OP_SHIFT;
                    n_count = r_count - CNT_W'(1);
                end else if (w_out_free) begin
                    n_sum      = w_sum_sat;
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = '0;
                    n_m_tdata[0]                = r_dom;
                    n_m_tdata[SIZE_W:1]         = w_size_ext[SIZE_W-1:0];
                    n_m_tdata[SIZE_W+SUM_W:SIZE_W+1] = w_sum_sat;
                    n_m_tdata[SIZE_W+SUM_W+1]   = r_ovf;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_sum      <= '0;
            r_dom      <= 1'b0;
            r_ovf      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_dom      <= n_dom;
            r_ovf      <= n_ovf;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

`default_nettype wire
